[hw/rtl/assert_macros.svh]
// Assertion macros shared by the UTF-8 validator RTL.
// Expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define U8V_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("u8v assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define U8V_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8v assertion failed");

// Consequent holds in the cycle after the antecedent.
`define U8V_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8v assertion failed");

`endif

[hw/rtl/u8v_pkg.sv]
// Package for the UTF-8 stream validator: types, codes and the DFA tables.
// No dependencies; used by u8v_out_if and all modules.
`timescale 1ns / 1ps

package u8v_pkg;

	typedef logic [3:0] cls_t;
	typedef logic [3:0] pos_t;
	typedef logic [2:0] status_t;
	typedef logic [2:0] len_t;
	typedef logic [1:0] seen_t;

	// Byte classes
	localparam cls_t CLS_ASCII = 4'd0;
	localparam cls_t CLS_C80   = 4'd1;
	localparam cls_t CLS_C90   = 4'd2;
	localparam cls_t CLS_CA0   = 4'd3;
	localparam cls_t CLS_BAD   = 4'd4;
	localparam cls_t CLS_C2    = 4'd5;
	localparam cls_t CLS_E0    = 4'd6;
	localparam cls_t CLS_E1    = 4'd7;
	localparam cls_t CLS_ED    = 4'd8;
	localparam cls_t CLS_F0    = 4'd9;
	localparam cls_t CLS_F1    = 4'd10;
	localparam cls_t CLS_F4    = 4'd11;

	// DFA positions
	localparam pos_t POS_ACCEPT = 4'd0;
	localparam pos_t POS_REJECT = 4'd1;
	localparam pos_t POS_ONE    = 4'd2;
	localparam pos_t POS_E0     = 4'd3;
	localparam pos_t POS_TWO    = 4'd4;
	localparam pos_t POS_ED     = 4'd5;
	localparam pos_t POS_F0     = 4'd6;
	localparam pos_t POS_THREE  = 4'd7;
	localparam pos_t POS_F4     = 4'd8;

	// Status codes
	localparam status_t ST_VALID      = 3'd0;
	localparam status_t ST_INVALID    = 3'd1;
	localparam status_t ST_INCOMPLETE = 3'd2;
	localparam status_t ST_OVERLONG   = 3'd3;
	localparam status_t ST_SURROGATE  = 3'd4;
	localparam status_t ST_TOO_LARGE  = 3'd5;

	typedef struct packed {
		status_t status;
		len_t    seq_length;
		seen_t   seq_seen;
	} dfa_res_t;

	// Map a byte to its character class.
	function automatic cls_t byte_class(input logic [7:0] b);
		cls_t c;
		if (b < 8'h80)       c = CLS_ASCII;
		else if (b < 8'h90)  c = CLS_C80;
		else if (b < 8'hA0)  c = CLS_C90;
		else if (b < 8'hC0)  c = CLS_CA0;
		else if (b < 8'hC2)  c = CLS_BAD;
		else if (b < 8'hE0)  c = CLS_C2;
		else if (b == 8'hE0) c = CLS_E0;
		else if (b == 8'hED) c = CLS_ED;
		else if (b < 8'hF0)  c = CLS_E1;
		else if (b == 8'hF0) c = CLS_F0;
		else if (b < 8'hF4)  c = CLS_F1;
		else if (b == 8'hF4) c = CLS_F4;
		else                 c = CLS_BAD;
		return c;
	endfunction

	// Transition table of the strict UTF-8 DFA.
	function automatic pos_t next_pos(input pos_t p, input cls_t c);
		logic cont;
		pos_t n;
		cont = (c == CLS_C80) || (c == CLS_C90) || (c == CLS_CA0);
		n = POS_REJECT;
		case (p)
			POS_ACCEPT: begin
				case (c)
					CLS_ASCII: n = POS_ACCEPT;
					CLS_C2:    n = POS_ONE;
					CLS_E0:    n = POS_E0;
					CLS_E1:    n = POS_TWO;
					CLS_ED:    n = POS_ED;
					CLS_F0:    n = POS_F0;
					CLS_F1:    n = POS_THREE;
					CLS_F4:    n = POS_F4;
					default:   n = POS_REJECT;
				endcase
			end
			POS_ONE:   if (cont) n = POS_ACCEPT;
			POS_E0:    if (c == CLS_CA0) n = POS_ONE;
			POS_TWO:   if (cont) n = POS_ONE;
			POS_ED:    if ((c == CLS_C80) || (c == CLS_C90)) n = POS_ONE;
			POS_F0:    if ((c == CLS_C90) || (c == CLS_CA0)) n = POS_TWO;
			POS_THREE: if (cont) n = POS_TWO;
			POS_F4:    if (c == CLS_C80) n = POS_TWO;
			default:   n = POS_REJECT;
		endcase
		return n;
	endfunction

	// Total sequence length once a lead byte reaches this position.
	function automatic len_t seq_total(input pos_t p);
		len_t l;
		case (p)
			POS_ACCEPT: l = 3'd1;
			POS_ONE:    l = 3'd2;
			POS_E0,
			POS_TWO,
			POS_ED:     l = 3'd3;
			POS_F0,
			POS_THREE,
			POS_F4:     l = 3'd4;
			default:    l = 3'd0;
		endcase
		return l;
	endfunction

	// Classify the error on the rejecting byte.
	function automatic status_t error_class(input pos_t p, input logic [7:0] b);
		status_t s;
		if (p == POS_ACCEPT && b >= 8'hC0 && b <= 8'hC1)      s = ST_OVERLONG;
		else if (p == POS_E0 && b >= 8'h80 && b <= 8'h9F)     s = ST_OVERLONG;
		else if (p == POS_ED && b >= 8'hA0 && b <= 8'hBF)     s = ST_SURROGATE;
		else if (p == POS_F0 && b >= 8'h80 && b <= 8'h8F)     s = ST_OVERLONG;
		else if (p == POS_F4 && b >= 8'h90 && b <= 8'hBF)     s = ST_TOO_LARGE;
		else                                                  s = ST_INVALID;
		return s;
	endfunction

endpackage

[hw/rtl/u8v_if.sv]
// Valid/ready channel interfaces for the UTF-8 validator byte and result items.
// Depends on u8v_pkg.
`timescale 1ns / 1ps

interface u8v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;
	logic       chunk_last;

	modport source(output valid, data_byte, restart, chunk_last, input ready);
	modport sink(input valid, data_byte, restart, chunk_last, output ready);
endinterface

interface u8v_out_if;
	logic             valid;
	logic             ready;
	u8v_pkg::status_t status;
	u8v_pkg::len_t    seq_length;
	u8v_pkg::seen_t   seq_seen;
	logic             chunk_done;

	modport source(output valid, status, seq_length, seq_seen, chunk_done, input ready);
	modport sink(input valid, status, seq_length, seq_seen, chunk_done, output ready);
endinterface

[hw/rtl/u8v_dfa.sv]
// DFA state and next-state logic of the UTF-8 validator.
// Depends on u8v_pkg for the class map, transition table and codes.
`timescale 1ns / 1ps

module u8v_dfa (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	input  logic              step,
	output u8v_pkg::dfa_res_t res
);

	u8v_pkg::pos_t    pos_q;
	u8v_pkg::len_t    need_q;
	u8v_pkg::seen_t   seen_q;

	u8v_pkg::pos_t    prev;
	u8v_pkg::pos_t    nxt;
	u8v_pkg::len_t    need_c;
	u8v_pkg::seen_t   seen_c;
	u8v_pkg::len_t    need_n;
	u8v_pkg::seen_t   seen_n;
	u8v_pkg::status_t status_n;

	// Clear to accept ahead of a restart byte, then take one transition
	always_comb begin
		prev   = restart ? u8v_pkg::POS_ACCEPT : pos_q;
		need_c = restart ? 3'd0 : need_q;
		seen_c = restart ? 2'd0 : seen_q;
		nxt    = u8v_pkg::next_pos(prev, u8v_pkg::byte_class(data_byte));
		need_n = need_c;
		seen_n = seen_c;
		if (nxt == u8v_pkg::POS_REJECT) begin
			status_n = u8v_pkg::error_class(prev, data_byte);
			need_n   = 3'd0;
			seen_n   = 2'd0;
		end else begin
			if (prev == u8v_pkg::POS_ACCEPT) begin
				if (nxt != u8v_pkg::POS_ACCEPT) begin
					need_n = u8v_pkg::seq_total(nxt);
					seen_n = 2'd1;
				end
			end else if (nxt == u8v_pkg::POS_ACCEPT) begin
				need_n = 3'd0;
				seen_n = 2'd0;
			end else begin
				seen_n = seen_c + 2'd1;
			end
			status_n = (nxt == u8v_pkg::POS_ACCEPT) ? u8v_pkg::ST_VALID
				: u8v_pkg::ST_INCOMPLETE;
		end
	end

	assign res.status     = status_n;
	assign res.seq_length = need_n;
	assign res.seq_seen   = seen_n;

	// Advance the state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= u8v_pkg::POS_ACCEPT;
			need_q <= 3'd0;
			seen_q <= 2'd0;
		end else if (step) begin
			pos_q  <= nxt;
			need_q <= need_n;
			seen_q <= seen_n;
		end
	end

endmodule

[hw/rtl/utf8_stream_validator_top.sv]
// Top level of the UTF-8 stream validator: input register, DFA, result register.
// Depends on u8v_pkg, u8v_in_if, u8v_out_if and u8v_dfa.
//
// Usage:
//   feed carries one byte item per handshake (data_byte, restart, chunk_last).
//   result carries one status item per byte (status, seq_length, seq_seen,
//   chunk_done). restart clears the DFA to the accept state before its byte.
//   A byte accepted on feed sits in the input register, and its result is
//   presented on result once it moves to the result register (two register
//   stages). Throughput: one byte per cycle while result is not stalled,
//   limited by the single DFA state update per byte between the two registers.
//   Reset (arst_n low) empties both registers and returns the DFA to accept
//   with zero sequence length.
//   When the receiver stalls, the result register holds its item and the input
//   register takes one more byte; feed.ready then drops until result moves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_validator_top (
	input logic         clk,
	input logic         arst_n,
	u8v_in_if.sink      feed,
	u8v_out_if.source   result
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              restart_s1;
	logic              last_s1;
	logic              out_valid_q;
	u8v_pkg::dfa_res_t res_q;
	logic              done_q;
	u8v_pkg::dfa_res_t res_c;
	logic              advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign feed.ready = !valid_s1 || advance;

	// Input register: load on accept, drop when the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.valid && feed.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			byte_s1    <= feed.data_byte;
			restart_s1 <= feed.restart;
			last_s1    <= feed.chunk_last;
		end
	end

	u8v_dfa u_dfa (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.step      (advance),
		.res       (res_c)
	);

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q  <= res_c;
			done_q <= last_s1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = res_q.status;
	assign result.seq_length = res_q.seq_length;
	assign result.seq_seen   = res_q.seq_seen;
	assign result.chunk_done = done_q;

	// A byte that cannot advance stays in the input register
	`U8V_ASSERT_NXT(a_s1_hold, valid_s1 && !advance, valid_s1)
	// Errors and completed characters carry no sequence in progress
	`U8V_ASSERT_IMP(a_done_len, out_valid_q && res_q.status != u8v_pkg::ST_INCOMPLETE, res_q.seq_length == 3'd0 && res_q.seq_seen == 2'd0)
	// An open sequence has between two and four bytes, some still missing
	`U8V_ASSERT_IMP(a_open_len, out_valid_q && res_q.status == u8v_pkg::ST_INCOMPLETE, res_q.seq_length >= 3'd2 && res_q.seq_length <= 3'd4 && res_q.seq_seen != 2'd0 && {1'b0, res_q.seq_seen} < res_q.seq_length)
	// Only defined status codes leave the block
	`U8V_ASSERT_IMP(a_status_range, out_valid_q, res_q.status <= u8v_pkg::ST_TOO_LARGE)

endmodule
